// ===== rtl/apq_pkg.sv =====
// Shared types and codes for the array priority queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package apq_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } state_t;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_MIN = 1'b1;

  localparam int RESULT_W = 32;
  localparam int VALUE_W  = 32;
  localparam int FILL_W   = 4;

endpackage

`default_nettype wire

// ===== rtl/apq_cmp.sv =====
// Shared signed comparator: is the candidate a better pick than the current best.
// Depends on apq_pkg for the priority mode codes.
`default_nettype none

module apq_cmp import apq_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic [DATA_WIDTH-1:0] cand,
  input  wire logic [DATA_WIDTH-1:0] best,
  input  wire logic                  mode,
  output logic                       better
);

  always_comb begin
    if (mode == MODE_MIN) begin
      better = signed'(cand) < signed'(best);
    end else begin
      better = signed'(cand) > signed'(best);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/apq_seq.sv =====
// Sequencer and entry memory: push, head-first scan, gap-closing shift.
// Depends on apq_pkg and apq_cmp.
`default_nettype none

module apq_seq import apq_pkg::*; #(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [1:0]          operation,
  input  wire logic [VALUE_W-1:0]  push_value,
  input  wire logic                mode,
  output logic                     busy,
  output logic                     done,
  output logic [RESULT_W-1:0]      result_value,
  output logic [1:0]               status,
  output logic [FILL_W-1:0]        fill_count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(DEPTH - 1) : PW'(p - 1'b1);
  endfunction

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;

  state_t                state, state_next;
  logic [PW-1:0]         head, head_next;
  logic [PW-1:0]         tail, tail_next;
  logic [CW-1:0]         count, count_next;
  logic [PW-1:0]         rd_pos, rd_pos_next;
  logic [CW-1:0]         cmp_cnt, cmp_cnt_next;
  logic [DATA_WIDTH-1:0] best_val, best_val_next;
  logic [PW-1:0]         best_pos, best_pos_next;
  logic [PW-1:0]         dst, dst_next;
  logic                  have, have_next;
  logic                  is_pop, is_pop_next;
  logic                  done_next;
  logic [RESULT_W-1:0]   result_value_next;
  logic [1:0]            status_next;
  logic [FILL_W-1:0]     fill_count_next;

  logic                  rd_en;
  logic [PW-1:0]         rd_addr;
  logic                  wr_en;
  logic [PW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  logic                  better;
  logic                  take;
  logic [DATA_WIDTH-1:0] sel_val;
  logic [PW-1:0]         sel_pos;
  logic [63:0]           push_wide;

  apq_cmp #(.DATA_WIDTH(DATA_WIDTH)) u_cmp (
    .cand   (rd_data),
    .best   (best_val),
    .mode   (mode),
    .better (better)
  );

  assign push_wide = {32'b0, push_value};
  assign busy      = (state != ST_IDLE);

  // first entry of a scan is taken unconditionally; ties keep the older one
  assign take    = (cmp_cnt == '0) || better;
  assign sel_val = take ? rd_data : best_val;
  assign sel_pos = take ? rd_pos : best_pos;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      have  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      have  <= have_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_pos       <= rd_pos_next;
    cmp_cnt      <= cmp_cnt_next;
    best_val     <= best_val_next;
    best_pos     <= best_pos_next;
    dst          <= dst_next;
    is_pop       <= is_pop_next;
    result_value <= result_value_next;
    status       <= status_next;
    fill_count   <= fill_count_next;
  end

  always_comb begin
    state_next        = state;
    head_next         = head;
    tail_next         = tail;
    count_next        = count;
    rd_pos_next       = rd_pos;
    cmp_cnt_next      = cmp_cnt;
    best_val_next     = best_val;
    best_pos_next     = best_pos;
    dst_next          = dst;
    have_next         = have;
    is_pop_next       = is_pop;
    done_next         = 1'b0;
    result_value_next = result_value;
    status_next       = status;
    fill_count_next   = fill_count;
    rd_en             = 1'b0;
    rd_addr           = head;
    wr_en             = 1'b0;
    wr_addr           = tail;
    wr_data           = push_wide[DATA_WIDTH-1:0];

    case (state)
      ST_IDLE: begin
        if (start) begin
          result_value_next = '0;
          status_next       = STAT_OK;
          fill_count_next   = FILL_W'(count);
          case (operation)
            OP_PUSH: begin
              done_next = 1'b1;
              if (count == CW'(DEPTH)) begin
                status_next = STAT_FULL;
              end else begin
                wr_en           = 1'b1;
                tail_next       = ptr_inc(tail);
                count_next      = CW'(count + 1'b1);
                fill_count_next = FILL_W'(CW'(count + 1'b1));
              end
            end
            OP_POP, OP_PEEK: begin
              if (count == '0) begin
                status_next = STAT_EMPTY;
                done_next   = 1'b1;
              end else begin
                rd_en        = 1'b1;
                rd_pos_next  = head;
                cmp_cnt_next = '0;
                is_pop_next  = (operation == OP_POP);
                state_next   = ST_SCAN;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        best_val_next = sel_val;
        best_pos_next = sel_pos;
        cmp_cnt_next  = CW'(cmp_cnt + 1'b1);
        if (CW'(cmp_cnt + 1'b1) == count) begin
          result_value_next = RESULT_W'(signed'(sel_val));
          status_next       = STAT_OK;
          if (is_pop) begin
            dst_next   = sel_pos;
            have_next  = 1'b0;
            state_next = ST_SHIFT;
          end else begin
            fill_count_next = FILL_W'(count);
            done_next       = 1'b1;
            state_next      = ST_IDLE;
          end
        end else begin
          rd_en       = 1'b1;
          rd_addr     = ptr_inc(rd_pos);
          rd_pos_next = ptr_inc(rd_pos);
        end
      end

      ST_SHIFT: begin
        // one entry moves toward the tail per beat; reads run one ahead
        if (dst == head) begin
          head_next       = ptr_inc(head);
          count_next      = CW'(count - 1'b1);
          fill_count_next = FILL_W'(CW'(count - 1'b1));
          done_next       = 1'b1;
          state_next      = ST_IDLE;
        end else if (!have) begin
          rd_en     = 1'b1;
          rd_addr   = ptr_dec(dst);
          have_next = 1'b1;
        end else begin
          wr_en    = 1'b1;
          wr_addr  = dst;
          wr_data  = rd_data;
          dst_next = ptr_dec(dst);
          if (ptr_dec(dst) != head) begin
            rd_en   = 1'b1;
            rd_addr = ptr_dec(ptr_dec(dst));
          end else begin
            have_next = 1'b0;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/array_priority_queue.sv =====
// Top level of the array priority queue: mode register and sequencer.
// Depends on apq_pkg, apq_seq (which holds apq_cmp).
//
//  channel   | signals                               | beat taken when
//  ----------+---------------------------------------+--------------------------
//  command   | start, busy, operation, push_value    | start && !busy
//  result    | done, result_value, status, fill_count| every cycle done is high
//  config    | cfg_valid, cfg_ready, cfg_data        | cfg_valid && cfg_ready
//
// Push, rejected and unknown operations: result in the cycle after the command beat.
// Peek: one memory read and one compare per entry, one entry at a time, since the
// entry memory has a single read port and the comparator is shared.
// Pop: the peek scan, then a shift that moves every entry between the head and the
// served entry one place toward the tail (one entry moved per cycle).
// Reset is synchronous; the queue comes up empty in max mode. Results cannot stall.
`default_nettype none

module array_priority_queue import apq_pkg::*; #(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          operation,
  input  wire logic [VALUE_W-1:0]  push_value,
  output logic                     done,
  output logic [RESULT_W-1:0]      result_value,
  output logic [1:0]               status,
  output logic [FILL_W-1:0]        fill_count,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_data
);

  logic priority_mode;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      priority_mode <= MODE_MAX;
    end else if (cfg_valid && cfg_ready) begin
      priority_mode <= cfg_data;
    end
  end

  apq_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .operation    (operation),
    .push_value   (push_value),
    .mode         (priority_mode),
    .busy         (busy),
    .done         (done),
    .result_value (result_value),
    .status       (status),
    .fill_count   (fill_count)
  );

endmodule

`default_nettype wire

// ===== rtl/apq_chk.sv =====
// Port-level checks for the array priority queue, bound to the top level.
// Depends on apq_pkg and array_priority_queue.
`default_nettype none

module apq_chk import apq_pkg::*; #(
  parameter int DEPTH = 8
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic [1:0]          operation,
  input wire logic                done,
  input wire logic [RESULT_W-1:0] result_value,
  input wire logic [1:0]          status,
  input wire logic [FILL_W-1:0]   fill_count
);

  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

  // a push always finishes in the cycle after its beat
  a_push_one_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && operation == OP_PUSH |=> done)
    else $error("push result not delivered in the next cycle");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status == STAT_FULL |-> fill_count == FULL_FILL)
    else $error("full reported with queue not full");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    done && status == STAT_EMPTY |-> fill_count == '0 && result_value == '0)
    else $error("empty reported with entries or nonzero value");

  // no result without a command beat or work in progress the cycle before
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start && !busy))
    else $error("result without a command");

endmodule

bind array_priority_queue apq_chk #(.DEPTH(DEPTH)) u_chk (.*);

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for array_priority_queue: directed table, then random phases with mode changes.
// Results are checked against the expectation given in a directed row, else against a local model of the queue.
// Depends on rtl/apq_pkg.sv and rtl/array_priority_queue.sv.
module tb import apq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = 8;
  localparam int QWIDTH = 32;
  localparam logic [1:0] OP_NONE = 2'd3;   // unused code, block answers OK and leaves the queue as it is
  localparam int NPHASE = 11;
  localparam int PHASE_ITEMS = 105;
  localparam int QUIET_TAIL = 150;         // last beats sent back to back

  typedef struct packed {
    logic [RESULT_W-1:0] value;
    logic [1:0]          status;
    logic [FILL_W-1:0]   count;
  } queue_result_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [1:0]         op;
    logic [VALUE_W-1:0] val;    // push data, or the mode for a config row
    logic               typed;  // expectation given in the row
    queue_result_t      want;
  } stim_row_t;

  localparam int NDIR = 26;
  stim_row_t dir_rows [NDIR] = '{
    '{ROW_CMD, OP_POP,  32'h0,        1'b1, '{32'h0, STAT_EMPTY, 4'd0}},
    '{ROW_CMD, OP_PEEK, 32'h0,        1'b1, '{32'h0, STAT_EMPTY, 4'd0}},
    '{ROW_CMD, OP_NONE, 32'hFFFFFFFF, 1'b1, '{32'h0, STAT_OK,    4'd0}},
    '{ROW_CMD, OP_PUSH, 32'h7FFFFFFF, 1'b1, '{32'h0, STAT_OK,    4'd1}},
    '{ROW_CMD, OP_PUSH, 32'h80000000, 1'b1, '{32'h0, STAT_OK,    4'd2}},
    '{ROW_CMD, OP_PUSH, 32'hFFFFFFFF, 1'b1, '{32'h0, STAT_OK,    4'd3}},
    '{ROW_CMD, OP_PUSH, 32'h0,        1'b1, '{32'h0, STAT_OK,    4'd4}},
    '{ROW_CMD, OP_PUSH, 32'd5,        1'b1, '{32'h0, STAT_OK,    4'd5}},
    '{ROW_CMD, OP_PUSH, 32'd5,        1'b1, '{32'h0, STAT_OK,    4'd6}},
    '{ROW_CMD, OP_PUSH, 32'h7FFFFFFF, 1'b1, '{32'h0, STAT_OK,    4'd7}},
    '{ROW_CMD, OP_PUSH, 32'd1,        1'b1, '{32'h0, STAT_OK,    4'd8}},
    '{ROW_CMD, OP_PUSH, 32'd2,        1'b1, '{32'h0, STAT_FULL,  4'd8}},
    '{ROW_CMD, OP_PEEK, 32'h0,        1'b1, '{32'h7FFFFFFF, STAT_OK, 4'd8}},
    // tie on max: head copy goes first, the later one needs a shift
    '{ROW_CMD, OP_POP,  32'h0,        1'b0, '0},
    '{ROW_CMD, OP_POP,  32'h0,        1'b0, '0},
    '{ROW_CFG, OP_PUSH, {31'b0, MODE_MIN}, 1'b0, '0},
    '{ROW_CMD, OP_PEEK, 32'h0,        1'b1, '{32'h80000000, STAT_OK, 4'd6}},
    '{ROW_CMD, OP_POP,  32'h0,        1'b0, '0},
    '{ROW_CMD, OP_POP,  32'h0,        1'b0, '0},
    '{ROW_CMD, OP_PUSH, 32'h80000000, 1'b0, '0},
    '{ROW_CMD, OP_POP,  32'h0,        1'b0, '0},
    '{ROW_CMD, OP_POP,  32'h0,        1'b0, '0},
    '{ROW_CMD, OP_POP,  32'h0,        1'b0, '0},
    '{ROW_CMD, OP_POP,  32'h0,        1'b0, '0},
    '{ROW_CMD, OP_POP,  32'h0,        1'b0, '0},
    '{ROW_CMD, OP_POP,  32'h0,        1'b1, '{32'h0, STAT_EMPTY, 4'd0}}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          operation = OP_PUSH;
  logic [VALUE_W-1:0]  push_value = '0;
  logic                done;
  logic [RESULT_W-1:0] result_value;
  logic [1:0]          status;
  logic [FILL_W-1:0]   fill_count;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_data = 1'b0;

  // queue model state
  logic [QWIDTH-1:0] pq_store [QDEPTH];
  int                pq_head = 0;
  int                pq_tail = 0;
  int                pq_count = 0;
  logic              pq_mode = MODE_MAX;

  queue_result_t results_due [$];
  int            errors = 0;

  array_priority_queue #(.DEPTH(QDEPTH), .DATA_WIDTH(QWIDTH)) DUT (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .operation(operation), .push_value(push_value),
    .done(done), .result_value(result_value), .status(status), .fill_count(fill_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic queue_result_t apply_queue_op(logic [1:0] op, logic [VALUE_W-1:0] val);
    queue_result_t r;
    int best;
    int pos;
    int gap;
    logic better;
    r = '0;
    if (op == OP_PUSH) begin
      if (pq_count >= QDEPTH) begin
        r.status = STAT_FULL;
      end else begin
        pq_store[pq_tail] = val;
        pq_tail = (pq_tail + 1) % QDEPTH;
        pq_count++;
      end
    end else if (op == OP_POP || op == OP_PEEK) begin
      if (pq_count == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        best = pq_head;
        for (int k = 1; k < pq_count; k++) begin
          pos = (pq_head + k) % QDEPTH;
          better = (pq_mode == MODE_MIN) ? ($signed(pq_store[pos]) < $signed(pq_store[best]))
                                         : ($signed(pq_store[pos]) > $signed(pq_store[best]));
          if (better) best = pos;
        end
        r.value = pq_store[best];
        if (op == OP_POP) begin
          // close the gap: older entries move one place toward the tail
          gap = (best + QDEPTH - pq_head) % QDEPTH;
          for (int j = gap; j > 0; j--)
            pq_store[(pq_head + j) % QDEPTH] = pq_store[(pq_head + j - 1) % QDEPTH];
          pq_head = (pq_head + 1) % QDEPTH;
          pq_count--;
        end
      end
    end
    r.count = pq_count[FILL_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && done) begin
      if (results_due.size() == 0) begin
        $display("%0t: result beat with nothing due: value %h status %0d count %0d",
                 $time, result_value, status, fill_count);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (result_value !== want.value) begin
          $display("%0t: result_value expected %h actual %h", $time, want.value, result_value);
          errors++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          errors++;
        end
        if (fill_count !== want.count) begin
          $display("%0t: fill_count expected %0d actual %0d", $time, want.count, fill_count);
          errors++;
        end
      end
    end
  end

  // Holds start until the command beat is taken, then books the expected result.
  task automatic send_command(logic [1:0] op, logic [VALUE_W-1:0] val, logic typed,
                              queue_result_t want);
    queue_result_t model;
    start <= 1'b1;
    operation <= op;
    push_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    model = apply_queue_op(op, val);
    results_due.push_back(typed ? want : model);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_priority_mode(logic m);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pq_mode = m;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: case ($urandom_range(0, 3))
           0: v = 32'h7FFFFFFF;
           1: v = 32'h80000000;
           2: v = 32'h0;
           default: v = 32'hFFFFFFFF;
         endcase
      1, 2, 3: v = $urandom_range(0, 6) - 3;  // narrow range makes ties frequent
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin
    int sent;
    int done_in_phase;
    int push_pct;
    int roll;
    logic idle_on;
    logic [1:0] op;
    logic [VALUE_W-1:0] val;

    sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        set_priority_mode(dir_rows[i].val[0]);
      else
        send_command(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < NPHASE; ph++) begin
      // phase boundary doubles as the full drain pause
      set_priority_mode(ph == 0 ? MODE_MAX : ph == 1 ? MODE_MIN : 1'($urandom_range(0, 1)));
      case ($urandom_range(0, 2))
        0: push_pct = 35;
        1: push_pct = 50;
        default: push_pct = 65;
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      done_in_phase = 0;
      while (done_in_phase < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 3)
          op = OP_NONE;
        else if (roll < 3 + push_pct)
          op = OP_PUSH;
        else
          op = ($urandom_range(0, 2) != 0) ? OP_POP : OP_PEEK;
        val = (op == OP_PUSH) ? pick_value() : 32'($urandom);
        if (idle_on && sent < NPHASE * PHASE_ITEMS - QUIET_TAIL
            && $urandom_range(0, 5) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        send_command(op, val, 1'b0, '0);
        if (op != OP_NONE) begin
          done_in_phase++;
          sent++;
        end
      end
    end

    drain_results();
    repeat (2 * QDEPTH + 8) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
